FILE: hw/rtl/tre_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tre_pkg
// Types and constants shared by the tristate remote encoder modules.
// ----------------------------------------------------------------------------
package tre_pkg;

    localparam int ADDRESS_TRITS = 8;
    localparam int DATA_TRITS    = 4;

    localparam int ADDR_BITS = 4 * ADDRESS_TRITS;
    localparam int DATA_BITS = 4 * DATA_TRITS;
    localparam int CODE_SEGS = ADDR_BITS + DATA_BITS;
    // code segments plus sync-high and sync-low
    localparam int SEG_W     = $clog2(CODE_SEGS + 2);
    localparam int IDX_W     = $clog2(CODE_SEGS);

    localparam logic [3:0] PAT_ONE   = 4'd5;
    localparam logic [3:0] PAT_ZERO  = 4'd10;
    localparam logic [3:0] PAT_FLOAT = 4'd6;

    localparam int DUR_W = 16;
    localparam int REP_W = 8;

    localparam logic [2:0] REG_SHORT     = 3'd0;
    localparam logic [2:0] REG_LONG      = 3'd1;
    localparam logic [2:0] REG_SYNC_HIGH = 3'd2;
    localparam logic [2:0] REG_SYNC_LOW  = 3'd3;
    localparam logic [2:0] REG_REPEATS   = 3'd4;

    localparam logic [DUR_W-1:0] SHORT_RESET     = 16'd4;
    localparam logic [DUR_W-1:0] LONG_RESET      = 16'd12;
    localparam logic [DUR_W-1:0] SYNC_HIGH_RESET = 16'd4;
    localparam logic [DUR_W-1:0] SYNC_LOW_RESET  = 16'd124;
    localparam logic [REP_W-1:0] REPEATS_RESET   = 8'd50;

    localparam logic OP_TICK  = 1'b0;
    localparam logic OP_START = 1'b1;

    typedef struct packed {
        logic                     operation;
        logic [ADDRESS_TRITS-1:0] address_trit_mask;
        logic [ADDRESS_TRITS-1:0] address_trit_value;
        logic [DATA_TRITS-1:0]    data_trit_mask;
        logic [DATA_TRITS-1:0]    data_trit_value;
    } cmd_item_t;

    typedef struct packed {
        logic rf_out;
        logic busy_res;
    } res_item_t;

    typedef struct packed {
        logic [DUR_W-1:0] zero_ticks;
        logic [DUR_W-1:0] one_ticks;
        logic [DUR_W-1:0] sync_hi_ticks;
        logic [DUR_W-1:0] sync_lo_ticks;
        logic [REP_W-1:0] frame_repeats;
    } cfg_t;

endpackage

FILE: hw/rtl/tre_encode.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tre_encode
// Maps address and data trits to the 4-bit-per-trit code pattern.
// ----------------------------------------------------------------------------
module tre_encode (
    input  tre_pkg::cmd_item_t                 item,
    output logic [tre_pkg::CODE_SEGS-1:0]      code
);
    import tre_pkg::*;

    logic [ADDR_BITS-1:0] addr_pat;
    logic [DATA_BITS-1:0] data_pat;

    for (genvar t = 0; t < ADDRESS_TRITS; t++) begin : g_addr
        always_comb
        begin
            if (!item.address_trit_mask[t])
                addr_pat[4*t +: 4] = PAT_FLOAT;
            else if (item.address_trit_value[t])
                addr_pat[4*t +: 4] = PAT_ONE;
            else
                addr_pat[4*t +: 4] = PAT_ZERO;
        end
    end

    // highest data trit goes into the lowest nibble
    for (genvar t = 0; t < DATA_TRITS; t++) begin : g_data
        always_comb
        begin
            if (!item.data_trit_mask[DATA_TRITS-1-t])
                data_pat[4*t +: 4] = PAT_FLOAT;
            else if (item.data_trit_value[DATA_TRITS-1-t])
                data_pat[4*t +: 4] = PAT_ONE;
            else
                data_pat[4*t +: 4] = PAT_ZERO;
        end
    end

    assign code = {data_pat, addr_pat};

endmodule

FILE: hw/rtl/tre_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tre_core
// Segment sequencer: holds the code, counts ticks and toggles the pin.
// ----------------------------------------------------------------------------
module tre_core (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          step,
    input  logic                          operation,
    input  logic [tre_pkg::CODE_SEGS-1:0] code,
    input  tre_pkg::cfg_t                 cfg,
    output tre_pkg::res_item_t            result
);
    import tre_pkg::*;

    logic [CODE_SEGS-1:0] code_reg,    code_next;
    logic [SEG_W-1:0]     seg_reg,     seg_next;
    logic [DUR_W-1:0]     ticks_reg,   ticks_next;
    logic [REP_W-1:0]     repeats_reg, repeats_next;
    logic                 pin_reg,     pin_next;
    logic                 active_reg,  active_next;

    logic                 start;
    logic [CODE_SEGS-1:0] base_code;
    logic [SEG_W-1:0]     base_seg;
    logic [REP_W-1:0]     base_rep;
    logic                 base_pin;
    logic                 code_bit;

    function automatic logic [DUR_W-1:0] at_least_one(input logic [DUR_W-1:0] d);
        return (d == '0) ? DUR_W'(1) : d;
    endfunction

    assign start     = step && (operation == OP_START);
    assign base_code = start ? code : code_reg;
    assign base_seg  = start ? '0 : seg_reg;
    assign base_pin  = start ? 1'b0 : pin_reg;
    assign base_rep  = start ? ((cfg.frame_repeats == '0) ? REP_W'(1) : cfg.frame_repeats)
                             : repeats_reg;
    assign code_bit  = base_code[base_seg[IDX_W-1:0]];

    always_comb
    begin
        code_next    = base_code;
        seg_next     = seg_reg;
        ticks_next   = ticks_reg;
        repeats_next = repeats_reg;
        pin_next     = pin_reg;
        active_next  = active_reg;
        if (start || (step && active_reg)) begin
            if (!start && ticks_reg > DUR_W'(1)) begin
                ticks_next = ticks_reg - DUR_W'(1);
            end else begin
                // begin the next segment
                pin_next     = ~base_pin;
                active_next  = 1'b1;
                repeats_next = base_rep;
                if (base_seg < SEG_W'(CODE_SEGS)) begin
                    ticks_next = at_least_one(code_bit ? cfg.one_ticks
                                                       : cfg.zero_ticks);
                    seg_next   = base_seg + SEG_W'(1);
                end else if (base_seg == SEG_W'(CODE_SEGS)) begin
                    ticks_next = at_least_one(cfg.sync_hi_ticks);
                    seg_next   = base_seg + SEG_W'(1);
                end else begin
                    seg_next = '0;
                    if (base_rep <= REP_W'(1)) begin
                        repeats_next = '0;
                        ticks_next   = '0;
                        active_next  = 1'b0;
                    end else begin
                        repeats_next = base_rep - REP_W'(1);
                        ticks_next   = at_least_one(cfg.sync_lo_ticks);
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            code_reg    <= '0;
            seg_reg     <= '0;
            ticks_reg   <= '0;
            repeats_reg <= '0;
            pin_reg     <= 1'b0;
            active_reg  <= 1'b0;
        end else begin
            code_reg    <= code_next;
            seg_reg     <= seg_next;
            ticks_reg   <= ticks_next;
            repeats_reg <= repeats_next;
            pin_reg     <= pin_next;
            active_reg  <= active_next;
        end
    end

    assign result.rf_out   = pin_next;
    assign result.busy_res = active_next;

endmodule

FILE: hw/rtl/tristate_rf_remote_encoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tristate_rf_remote_encoder
// Tristate remote-control code generator driving one RF pin level.
// ----------------------------------------------------------------------------
//  channel | direction | handshake        | payload
//  cmd     | in        | valid / stall    | cmd_item_t (tick or start request)
//  res     | out       | valid / stall    | res_item_t (pin level, busy)
//  cfg     | in        | valid / ready    | 3-bit index, 16-bit data
//
//  One request per cycle unless res stalls; each result passes through an input
//  register, then the sequencer step into the result register.
//  Reset sets the registers to their defaults and leaves the pin low, idle.
//  A stalled result holds the pipeline; cmd stalls only while both stages
//  are full. cfg_ready is always high.
// ----------------------------------------------------------------------------
module tristate_rf_remote_encoder (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cmd_valid,
    output logic               cmd_stall,
    input  tre_pkg::cmd_item_t cmd_data,
    output logic               res_valid,
    input  logic               res_stall,
    output tre_pkg::res_item_t res_data,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [15:0]        cfg_data
);
    import tre_pkg::*;

    cfg_t                 cfg_reg;
    logic                 s1_valid_reg;
    cmd_item_t            s1_item_reg;
    logic                 res_valid_reg;
    res_item_t            res_data_reg;
    logic                 advance;
    logic [CODE_SEGS-1:0] code;
    res_item_t            result;

    assign advance   = !res_valid_reg || !res_stall;
    assign cmd_stall = s1_valid_reg && !advance;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cfg_reg.zero_ticks    <= SHORT_RESET;
            cfg_reg.one_ticks     <= LONG_RESET;
            cfg_reg.sync_hi_ticks <= SYNC_HIGH_RESET;
            cfg_reg.sync_lo_ticks <= SYNC_LOW_RESET;
            cfg_reg.frame_repeats <= REPEATS_RESET;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                REG_SHORT:     cfg_reg.zero_ticks    <= cfg_data;
                REG_LONG:      cfg_reg.one_ticks     <= cfg_data;
                REG_SYNC_HIGH: cfg_reg.sync_hi_ticks <= cfg_data;
                REG_SYNC_LOW:  cfg_reg.sync_lo_ticks <= cfg_data;
                REG_REPEATS:   cfg_reg.frame_repeats <= cfg_data[REP_W-1:0];
                default:       ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            s1_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end else begin
            if (!s1_valid_reg || advance)
                s1_valid_reg <= cmd_valid;
            if (advance)
                res_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!s1_valid_reg || advance)
            s1_item_reg <= cmd_data;
        if (advance)
            res_data_reg <= result;
    end

    tre_encode u_encode (
        .item (s1_item_reg),
        .code (code)
    );

    tre_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (s1_valid_reg && advance),
        .operation (s1_item_reg.operation),
        .code      (code),
        .cfg       (cfg_reg),
        .result    (result)
    );

    assign res_valid = res_valid_reg;
    assign res_data  = res_data_reg;

endmodule

FILE: hw/rtl/tre_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tre_checker
// Port-level checks for the tristate remote encoder, bound to the top level.
// ----------------------------------------------------------------------------
module tre_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               cmd_stall,
    input logic               res_valid,
    input logic               res_stall,
    input tre_pkg::res_item_t res_data,
    input logic               cfg_ready
);
    import tre_pkg::*;

    // hold a stalled result
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> res_valid && $stable(res_data))
        else $error("stalled result changed");

    // idle means pin low
    a_idle_low: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_data.busy_res |-> !res_data.rf_out)
        else $error("pin high while idle");

    // requests back up only behind a stalled result
    a_stall_src: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_stall |-> res_valid && res_stall)
        else $error("request stalled without a stalled result");

    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_ready)
        else $error("configuration port not ready");

endmodule

bind tristate_rf_remote_encoder tre_checker u_tre_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_stall (cmd_stall),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res_data  (res_data),
    .cfg_ready (cfg_ready)
);

FILE: test/tb_tristate_rf_remote_encoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_tristate_rf_remote_encoder
// Self-checking bench for the tristate RF remote encoder. Tick and start
// requests go in with random gaps, and a local pin sequencer predicts the pin
// level and busy flag that each one produces. Register writes happen between
// phases, with the request pipeline drained.
// ----------------------------------------------------------------------------
module tb_tristate_rf_remote_encoder;

    import tre_pkg::*;

    localparam int CLK_HALF     = 5;
    localparam int PIPE_LATENCY = 2;
    localparam int STALL_LIMIT  = 5000;
    localparam int RANDOM_ITEMS = 1000;
    localparam int LONG_HOLD    = 250;
    localparam logic [2:0] REG_UNUSED_FIRST = REG_REPEATS + 3'd1;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       cmd_valid = 1'b0;
    logic       cmd_stall;
    cmd_item_t  cmd_data = '0;
    logic       res_valid;
    logic       res_stall = 1'b0;
    res_item_t  res_data;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic [2:0] cfg_index = '0;
    logic [15:0] cfg_data = '0;

    // pin sequencer copy: registers
    int unsigned short_ticks    = 32'(SHORT_RESET);
    int unsigned long_ticks     = 32'(LONG_RESET);
    int unsigned sync_high_ticks = 32'(SYNC_HIGH_RESET);
    int unsigned sync_low_ticks = 32'(SYNC_LOW_RESET);
    int unsigned frames_per_start = 32'(REPEATS_RESET);

    // pin sequencer copy: state
    logic [ADDR_BITS-1:0] addr_code = '0;
    logic [DATA_BITS-1:0] data_code = '0;
    int unsigned seg_pos     = 0;
    int unsigned ticks_left  = 0;
    int unsigned frames_left = 0;
    logic        pin_level   = 1'b0;
    logic        sending     = 1'b0;

    res_item_t expected_pin_q[$];
    int        errors = 0;
    int        quiet_cycles = 0;
    int        hold_request = 0;
    int        rx_pause_left = 0;
    bit        tx_steady = 1'b0;
    bit        rx_steady = 1'b0;

    tristate_rf_remote_encoder u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd_data  (cmd_data),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_data  (res_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #CLK_HALF clk = ~clk;

    function automatic int pick_pause();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 30);
    endfunction

    function automatic logic [3:0] trit_pattern(input logic driven, input logic level);
        if (!driven)
            return PAT_FLOAT;
        return level ? PAT_ONE : PAT_ZERO;
    endfunction

    function automatic int unsigned at_least_one(input int unsigned ticks);
        return (ticks == 0) ? 1 : ticks;
    endfunction

    // toggle the pin and load the length of the segment that starts now
    task advance_segment();
        logic code_bit;
        pin_level = ~pin_level;
        if (seg_pos < CODE_SEGS) begin
            code_bit = (seg_pos < ADDR_BITS) ? addr_code[seg_pos] : data_code[seg_pos - ADDR_BITS];
            ticks_left = at_least_one(code_bit ? long_ticks : short_ticks);
            seg_pos++;
        end
        else if (seg_pos == CODE_SEGS) begin
            ticks_left = at_least_one(sync_high_ticks);
            seg_pos++;
        end
        else begin
            seg_pos = 0;
            if (frames_left <= 1) begin
                // last sync-low: drop to idle right away
                frames_left = 0;
                ticks_left = 0;
                sending = 1'b0;
            end
            else begin
                frames_left--;
                ticks_left = at_least_one(sync_low_ticks);
            end
        end
    endtask

    task step_encoder_model(input cmd_item_t item, output res_item_t level);
        if (item.operation == OP_START) begin
            for (int t = 0; t < ADDRESS_TRITS; t++)
                addr_code[4*t +: 4] = trit_pattern(item.address_trit_mask[t],
                                                   item.address_trit_value[t]);
            // highest data trit goes out first
            for (int t = 0; t < DATA_TRITS; t++)
                data_code[4*t +: 4] = trit_pattern(item.data_trit_mask[DATA_TRITS-1-t],
                                                   item.data_trit_value[DATA_TRITS-1-t]);
            seg_pos = 0;
            frames_left = (frames_per_start == 0) ? 1 : frames_per_start;
            pin_level = 1'b0;
            sending = 1'b1;
            advance_segment();
        end
        else if (sending) begin
            if (ticks_left > 1)
                ticks_left--;
            else
                advance_segment();
        end
        level.rf_out = pin_level;
        level.busy_res = sending;
    endtask

    function automatic cmd_item_t make_start(input logic [7:0] a_mask, input logic [7:0] a_val,
                                             input logic [3:0] d_mask, input logic [3:0] d_val);
        cmd_item_t item;
        item.operation = OP_START;
        item.address_trit_mask = a_mask;
        item.address_trit_value = a_val;
        item.data_trit_mask = d_mask;
        item.data_trit_value = d_val;
        return item;
    endfunction

    function automatic cmd_item_t random_start();
        return make_start(8'($urandom), 8'($urandom), 4'($urandom), 4'($urandom));
    endfunction

    // trit fields ride along with random content; the block ignores them
    function automatic cmd_item_t tick_item();
        cmd_item_t item;
        item = random_start();
        item.operation = OP_TICK;
        return item;
    endfunction

    // called and returns at a falling edge
    task automatic send_request(input cmd_item_t item);
        int gap;
        res_item_t level;
        gap = tx_steady ? 0 : pick_pause();
        if (gap > 0) begin
            cmd_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        cmd_valid <= 1'b1;
        cmd_data <= item;
        @(posedge clk);
        while (cmd_stall)
            @(posedge clk);
        step_encoder_model(item, level);
        expected_pin_q.push_back(level);
        @(negedge clk);
    endtask

    task automatic send_ticks(input int count);
        repeat (count) send_request(tick_item());
    endtask

    // run ticks until the sequencer goes idle, then a few ignored ones
    task automatic run_to_idle();
        while (sending)
            send_request(tick_item());
        send_ticks($urandom_range(1, 3));
    endtask

    task automatic wait_for_drain();
        cmd_valid <= 1'b0;
        while (expected_pin_q.size() != 0)
            @(negedge clk);
        repeat (PIPE_LATENCY + 2) @(negedge clk);
    endtask

    task automatic write_reg(input logic [2:0] index, input logic [15:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (index)
            REG_SHORT:     short_ticks = 32'(value);
            REG_LONG:      long_ticks = 32'(value);
            REG_SYNC_HIGH: sync_high_ticks = 32'(value);
            REG_SYNC_LOW:  sync_low_ticks = 32'(value);
            REG_REPEATS:   frames_per_start = 32'(value[REP_W-1:0]);
            default:       ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    task automatic write_all_regs(input logic [15:0] s, input logic [15:0] l,
                                  input logic [15:0] sh, input logic [15:0] sl,
                                  input logic [15:0] reps);
        wait_for_drain();
        write_reg(REG_SHORT, s);
        write_reg(REG_LONG, l);
        write_reg(REG_SYNC_HIGH, sh);
        write_reg(REG_SYNC_LOW, sl);
        write_reg(REG_REPEATS, reps);
    endtask

    // ------------------------------------------------------------------
    // test tasks
    // ------------------------------------------------------------------

    // reset defaults: idle ticks, then all-one, all-zero, all-floating, mixed codes
    task automatic test_idle_and_codes();
        send_ticks(2);
        send_request(make_start(8'hFF, 8'hFF, 4'hF, 4'hF));
        send_ticks(3);
        send_request(make_start(8'hFF, 8'h00, 4'hF, 4'h0));
        send_ticks(2);
        send_request(make_start(8'h00, 8'hFF, 4'h0, 4'hF));
        send_ticks(2);
        send_request(make_start(8'h0F, 8'h35, 4'h9, 4'h3));
        send_ticks(14);
    endtask

    // zero in every register acts as one: single frame of one-tick segments
    task automatic test_zero_registers();
        write_all_regs('0, '0, '0, '0, '0);
        send_request(random_start());
        run_to_idle();
    endtask

    task automatic test_register_extremes();
        // upper byte of the repeat write must be dropped
        write_all_regs(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        for (int k = 0; k < 3; k++)
            write_reg(REG_UNUSED_FIRST + 3'(k), 16'($urandom));
        tx_steady = 1'b1;
        rx_steady = 1'b1;
        // A0 driven high: first segment is a full-width long one, pin stays high
        send_request(make_start(8'h01, 8'h01, 4'h0, 4'h0));
        send_ticks(40);
        tx_steady = 1'b0;
        rx_steady = 1'b0;
        // restart while busy with A0 floating
        send_request(make_start(8'h00, 8'h00, 4'hF, 4'hA));
        send_ticks(3);
        write_all_regs(16'd1, 16'd1, 16'd1, 16'd1, 16'd255);
        send_request(random_start());
        send_ticks(130);
    endtask

    // durations change while a frame is on the air
    task automatic test_midframe_update();
        write_all_regs(16'd2, 16'd3, 16'd2, 16'd5, 16'd2);
        send_request(random_start());
        send_ticks(20);
        wait_for_drain();
        write_reg(REG_SHORT, 16'd1);
        write_reg(REG_LONG, 16'd5);
        send_ticks(30);
        wait_for_drain();
        write_reg(REG_SYNC_LOW, 16'd3);
        write_reg(REG_REPEATS, 16'd1);
        run_to_idle();
    endtask

    // hold the result side for a long stretch while requests keep coming
    task automatic test_backpressure();
        hold_request = LONG_HOLD;
        tx_steady = 1'b1;
        send_request(random_start());
        send_ticks(39);
        tx_steady = 1'b0;
        wait_for_drain();
        send_ticks(10);
    endtask

    task automatic test_random_traffic();
        int counted;
        int r;
        logic [2:0] index;
        logic [15:0] value;
        counted = 0;
        while (counted < RANDOM_ITEMS) begin
            if ($urandom_range(0, 3) == 0) begin
                wait_for_drain();
                repeat ($urandom_range(1, 3)) begin
                    index = 3'($urandom_range(0, 7));
                    case (index)
                        REG_REPEATS:
                            value = {8'($urandom), 8'($urandom_range(0, 3))};
                        REG_SYNC_HIGH, REG_SYNC_LOW:
                            value = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(20, 60))
                                                                : 16'($urandom_range(0, 4));
                        REG_SHORT, REG_LONG:
                            value = 16'($urandom_range(0, 4));
                        default:
                            value = 16'($urandom);
                    endcase
                    write_reg(index, value);
                end
            end
            tx_steady = ($urandom_range(0, 4) == 0);
            rx_steady = ($urandom_range(0, 4) == 0);
            send_request(random_start());
            counted++;
            while (sending) begin
                r = $urandom_range(0, 199);
                if (r == 0)
                    break;          // abandon: next start restarts mid-frame
                if (r == 1)
                    send_request(random_start());
                else
                    send_request(tick_item());
                counted++;
            end
            send_ticks($urandom_range(0, 3));
        end
        tx_steady = 1'b0;
        rx_steady = 1'b0;
    endtask

    // ------------------------------------------------------------------
    // result side: random stall, long hold on request
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (hold_request > 0) begin
            rx_pause_left = hold_request;
            hold_request = 0;
        end
        if (rx_pause_left > 0) begin
            res_stall <= 1'b1;
            rx_pause_left--;
        end
        else if (rx_steady) begin
            res_stall <= 1'b0;
        end
        else begin
            rx_pause_left = pick_pause();
            res_stall <= (rx_pause_left > 0);
            if (rx_pause_left > 0)
                rx_pause_left--;
        end
    end

    always @(posedge clk)
    begin
        res_item_t want;
        if (rst_n && res_valid && !res_stall) begin
            if (expected_pin_q.size() == 0) begin
                errors++;
                $display("%0t: unexpected result rf_out=%0b busy_res=%0b",
                         $time, res_data.rf_out, res_data.busy_res);
            end
            else begin
                want = expected_pin_q.pop_front();
                if (res_data.rf_out !== want.rf_out) begin
                    errors++;
                    $display("%0t: rf_out mismatch: expected %0b, actual %0b",
                             $time, want.rf_out, res_data.rf_out);
                end
                if (res_data.busy_res !== want.busy_res) begin
                    errors++;
                    $display("%0t: busy_res mismatch: expected %0b, actual %0b",
                             $time, want.busy_res, res_data.busy_res);
                end
            end
        end
    end

    // end the run if nothing moves for too long
    always @(posedge clk)
    begin
        if ((cmd_valid && !cmd_stall) || (res_valid && !res_stall) || (cfg_valid && cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t: timeout, %0d results outstanding", $time, expected_pin_q.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial
    begin
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        test_idle_and_codes();
        test_zero_registers();
        test_register_extremes();
        test_midframe_update();
        test_backpressure();
        test_random_traffic();
        wait_for_drain();
        repeat (PIPE_LATENCY + 4) @(negedge clk);
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

FILE: tristate_rf_remote_encoder.f
hw/rtl/tre_pkg.sv
hw/rtl/tre_encode.sv
hw/rtl/tre_core.sv
hw/rtl/tristate_rf_remote_encoder.sv
hw/rtl/tre_checker.sv
test/tb_tristate_rf_remote_encoder.sv
